/* hdl/text_console_char_writer_macros.svh */
// Assertion macros shared by the checker of the text console.
// Depends on nothing; expects signals named clock and reset in scope.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console check failed");

`endif

/* hdl/tcw_pkg.sv */
// Package of the text console: geometry, character codes, kinds and the cursor step type.
// Used by the cursor decoder, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   // field widths of the ports
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int POS_W  = 11;
   localparam int IDX_W  = 11;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int CNT_W  = $clog2(CELLS);

   localparam int TAB_STEP = 8;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h07;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic              wr_en;
      logic [COL_W-1:0]  wr_col;
      logic [CHAR_W-1:0] wr_char;
      logic [ROW_W-1:0]  next_row;
      logic [COL_W-1:0]  next_col;
      logic              scroll;
   } cursor_step_type;

   function automatic logic [CNT_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      cell_addr = CNT_W'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

/* hdl/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hdl/tcw_cursor.sv */
// Cursor step decoder: new cursor, cell write and scroll request for one written byte.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cursor
   import tcw_pkg::*;
(
   input  logic [ROW_W-1:0]  cur_row,
   input  logic [COL_W-1:0]  cur_col,
   input  logic [CHAR_W-1:0] char_code,
   output cursor_step_type   step
);

   logic [COL_W:0]   tab_col;
   logic             last_row;
   logic [ROW_W-1:0] adv_row;

   assign tab_col  = {1'b0, cur_col} + (COL_W + 1)'(TAB_STEP);
   assign last_row = (cur_row == ROW_W'(ROWS - 1));
   assign adv_row  = last_row ? cur_row : cur_row + ROW_W'(1);

   always_comb begin
      step          = '0;
      step.next_row = cur_row;
      step.next_col = cur_col;
      step.wr_col   = cur_col;
      step.wr_char  = char_code;
      unique case (char_code)
         CH_BACKSPACE: begin
            if (cur_col != '0) begin
               step.wr_en    = 1'b1;
               step.wr_col   = cur_col - COL_W'(1);
               step.wr_char  = CH_BLANK;
               step.next_col = cur_col - COL_W'(1);
            end
         end
         CH_TAB: begin
            if (tab_col > (COL_W + 1)'(COLUMNS - 1)) begin
               step.next_col = COL_W'(COLUMNS - 1);
            end else begin
               step.next_col = tab_col[COL_W-1:0];
            end
         end
         CH_LF: begin
            step.next_col = '0;
            step.next_row = adv_row;
            step.scroll   = last_row;
         end
         CH_CR: begin
            step.next_col = '0;
         end
         default: begin
            step.wr_en = 1'b1;
            if (cur_col == COL_W'(COLUMNS - 1)) begin
               step.next_col = '0;
               step.next_row = adv_row;
               step.scroll   = last_row;
            end else begin
               step.next_col = cur_col + COL_W'(1);
            end
         end
      endcase
   end

endmodule

/* hdl/text_console_char_writer.sv */
// Text console top level: 80x25 cell store in a RAM, cursor, sequencer for scroll and clear.
// Busy is high from a taken item through its reply state; no new item is taken before then.
// A scroll copies every row but the top one up by one row, then blanks the bottom row in the
// current colour; a clear blanks every cell and homes the cursor. Both use the single RAM port pair.
// Reset: synchronous; a fill pass writes 0x0720 to every cell while busy is high.
// Results go out on a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module text_console_char_writer
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [IDX_W-1:0]  req_cell_index,
   output logic              rsp_strobe,
   output logic [ROW_W-1:0]  rsp_cursor_row_out,
   output logic [COL_W-1:0]  rsp_cursor_col_out,
   output logic [POS_W-1:0]  rsp_cursor_position,
   output logic [CELL_W-1:0] rsp_cell_word,
   output logic              rsp_scrolled,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data
);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCROLL = 5'b00100,
      ST_BLANK  = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ATTR_W-1:0] color_ff;
   logic              strobe_ff, strobe_in;
   logic              sc_ff, sc_in;
   logic              rd_ok_ff, rd_ok_in;

   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [CELL_W-1:0] rsp_word_ff;
   logic              rsp_sc_ff;

   // RAM port signals
   logic              ram_wr_en;
   logic [CNT_W-1:0]  ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [CNT_W-1:0]  ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   cursor_step_type   step;
   logic              accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   tcw_cursor u_cursor (
      .cur_row   (row_ff),
      .cur_col   (col_ff),
      .char_code (req_char_code),
      .step      (step)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      sc_in       = sc_ff;
      rd_ok_in    = rd_ok_ff;
      strobe_in   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff;
      ram_wr_data = {color_ff, CH_BLANK};
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff + CNT_W'(COLUMNS);
      unique case (state_ff)
         ST_INIT: begin
            // fill pass after reset: the colour here is the reset attribute, not the register
            ram_wr_en   = 1'b1;
            ram_wr_data = {RESET_COLOR, CH_BLANK};
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               sc_in    = 1'b0;
               rd_ok_in = 1'b0;
               state_in = ST_REPLY;
               case (req_kind)
                  KIND_WRITE: begin
                     // store the byte first: a following scroll must move it up
                     ram_wr_en   = step.wr_en;
                     ram_wr_addr = cell_addr(row_ff, step.wr_col);
                     ram_wr_data = {color_ff, step.wr_char};
                     row_in      = step.next_row;
                     col_in      = step.next_col;
                     if (step.scroll) begin
                        sc_in    = 1'b1;
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end
                  end
                  KIND_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_BLANK;
                  end
                  KIND_READ: begin
                     if (int'(req_cell_index) < CELLS) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = CNT_W'(req_cell_index);
                        rd_ok_in    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // read one row ahead, write back the word read in the previous cycle
            ram_rd_en   = (int'(cnt_ff) < CELLS - COLUMNS);
            ram_wr_en   = (cnt_ff != '0);
            ram_wr_addr = cnt_ff - CNT_W'(1);
            ram_wr_data = ram_rd_data;
            if (cnt_ff == CNT_W'(CELLS - COLUMNS)) begin
               // hold the count: blanking starts at the first cell of the bottom row
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_BLANK: begin
            ram_wr_en = 1'b1;
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_REPLY;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_REPLY: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         cnt_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         color_ff  <= RESET_COLOR;
         strobe_ff <= 1'b0;
         sc_ff     <= 1'b0;
         rd_ok_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         strobe_ff <= strobe_in;
         sc_ff     <= sc_in;
         rd_ok_ff  <= rd_ok_in;
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   // result registers: load in the reply cycle, the RAM read data is valid there
   always_ff @(posedge clock) begin
      if (state_ff == ST_REPLY) begin
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
         rsp_pos_ff  <= POS_W'(int'(row_ff) * COLUMNS + int'(col_ff));
         rsp_word_ff <= rd_ok_ff ? ram_rd_data : '0;
         rsp_sc_ff   <= sc_ff;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_cursor_row_out  = rsp_row_ff;
   assign rsp_cursor_col_out  = rsp_col_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_word       = rsp_word_ff;
   assign rsp_scrolled        = rsp_sc_ff;

endmodule

/* hdl/tcw_checker.sv */
// Port-level checker of the text console, attached to the top level by a bind.
// Depends on tcw_pkg and text_console_char_writer_macros.svh.
`timescale 1ns / 1ps
`include "text_console_char_writer_macros.svh"

module tcw_checker
   import tcw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [ROW_W-1:0]  rsp_cursor_row_out,
   input logic [COL_W-1:0]  rsp_cursor_col_out,
   input logic [POS_W-1:0]  rsp_cursor_position
);

   logic [POS_W-1:0] pos_expect;

   assign pos_expect = POS_W'(int'(rsp_cursor_row_out) * COLUMNS + int'(rsp_cursor_col_out));

   // a taken item keeps the block busy until its result has gone out
   `TCW_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy && !rsp_strobe)
   // a result appears only once the block is free again, and never twice in a row
   `TCW_ASSERT_NOW(a_strobe_when_free, rsp_strobe, !busy)
   `TCW_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   // reported cursor stays on screen and its linear position agrees
   `TCW_ASSERT_NOW(a_cursor_range, rsp_strobe,
      (int'(rsp_cursor_row_out) < ROWS) && (int'(rsp_cursor_col_out) < COLUMNS))
   `TCW_ASSERT_NOW(a_position_match, rsp_strobe, rsp_cursor_position == pos_expect)

endmodule

bind text_console_char_writer tcw_checker u_checker (.*);
